// File: design/cri_pkg.sv
package cri_pkg;

    localparam int SAMPLE_BITS    = 8;
    localparam int FRAC_BITS      = 8;
    localparam int ROW_BITS       = 32;
    localparam int TAPS           = 4;
    localparam int GAIN_BITS      = 16;
    localparam int GAIN_FRAC      = 8;
    localparam int OFFSET_BITS    = 9;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // Pipeline stages, in order of travel
    localparam int NUM_STAGES = 9;
    localparam int ST_SQR     = 0;
    localparam int ST_CUBE    = 1;
    localparam int ST_WGT     = 2;
    localparam int ST_YMUL    = 3;
    localparam int ST_YSUM    = 4;
    localparam int ST_XMUL    = 5;
    localparam int ST_XSUM    = 6;
    localparam int ST_GAIN    = 7;
    localparam int ST_OUT     = 8;

    // Datapath widths
    localparam int T2_W   = 2 * FRAC_BITS;
    localparam int T3_W   = 3 * FRAC_BITS;
    localparam int LIN_W  = FRAC_BITS + 1;
    localparam int QUAD_W = 2 * FRAC_BITS + 1;
    localparam int WGT_W  = 3 * FRAC_BITS + 3;
    localparam int COL_W  = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int VAL_W  = SAMPLE_BITS + FRAC_BITS + 3;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_INTERP_MODE     = 2'd0,
        REG_CONTRAST_GAIN   = 2'd1,
        REG_CONTRAST_OFFSET = 2'd2
    } cfg_reg_t;

    typedef logic [SAMPLE_BITS-1:0]     sample_t;
    typedef sample_t [TAPS-1:0]         smp_row_t;
    typedef smp_row_t [TAPS-1:0]        smp_block_t;
    typedef logic [FRAC_BITS-1:0]       frac_t;
    typedef logic signed [WGT_W-1:0]    wgt_t;
    typedef wgt_t [TAPS-1:0]            wgt_vec_t;
    typedef logic [QUAD_W-1:0]          quad_t;
    typedef quad_t [TAPS-1:0]           quad_vec_t;
    typedef logic signed [VAL_W-1:0]    val_t;
    typedef logic [NUM_STAGES-1:0]      stage_vec_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] samples_row0;
        logic [ROW_BITS-1:0] samples_row1;
        logic [ROW_BITS-1:0] samples_row2;
        logic [ROW_BITS-1:0] samples_row3;
        logic [7:0]          frac_x;
        logic [7:0]          frac_y;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       clipped;
    } out_item_t;

    // Stage handshake between the pipeline control and the datapath
    typedef struct packed {
        stage_vec_t load;
    } pipe_ctl_t;

endpackage

// File: design/cell_interpolator_with_contrast.sv
// Cell interpolator with contrast: takes a 4x4 neighborhood of 8-bit samples
// plus an 8-bit fractional position in x and y, interpolates one sample
// (Catmull-Rom bicubic over the full 4x4, or bilinear over the center 2x2),
// then applies gain (unsigned Q8.8) and a signed offset, floors, and
// saturates to 0..255 with a clip flag. The datapath is a nine-stage
// pipeline that carries each request through to the m_ side, and a new
// request is taken every cycle as long as the result side keeps up; the
// per-stage ready chain fills bubbles, so a stall on m_ready only stops
// s_ready once every stage holds a request.
// Configuration (mode, gain, offset) is written through the cfg_ port and
// must only change while no request is in flight.
module cell_interpolator_with_contrast
    import cri_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  in_item_t                  s_data,

    output logic                      m_valid,
    input  logic                      m_ready,
    output out_item_t                 m_data,

    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

    logic                          mode_reg, mode_next;
    logic [GAIN_BITS-1:0]          gain_reg, gain_next;
    logic signed [OFFSET_BITS-1:0] offset_reg, offset_next;

    pipe_ctl_t  ctl;
    wgt_vec_t   wy, wx;
    quad_vec_t  quad;
    smp_block_t smp;
    val_t       val;

    // Register writes; unknown indices drop the write
    always_comb begin
        mode_next   = mode_reg;
        gain_next   = gain_reg;
        offset_next = offset_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_INTERP_MODE:     mode_next   = cfg_wdata[0];
                REG_CONTRAST_GAIN:   gain_next   = cfg_wdata[GAIN_BITS-1:0];
                REG_CONTRAST_OFFSET: offset_next = cfg_wdata[OFFSET_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            gain_reg   <= GAIN_BITS'(1) << GAIN_FRAC;
            offset_reg <= '0;
        end else begin
            mode_reg   <= mode_next;
            gain_reg   <= gain_next;
            offset_reg <= offset_next;
        end
    end

    // Valid bits and per-stage advance enables
    cri_pipe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    // Stages 1-3: fraction powers, cubic and bilinear weights
    cri_front u_front (
        .aclk    (aclk),
        .ctl     (ctl),
        .in_data (s_data),
        .wy      (wy),
        .wx      (wx),
        .quad    (quad),
        .smp     (smp)
    );

    // Stages 4-7: vertical pass, horizontal pass, mode select
    cri_filter u_filter (
        .aclk        (aclk),
        .ctl         (ctl),
        .interp_mode (mode_reg),
        .wy          (wy),
        .wx          (wx),
        .quad        (quad),
        .smp         (smp),
        .val         (val)
    );

    // Stages 8-9: gain, offset, saturation, output register
    cri_contrast u_contrast (
        .aclk            (aclk),
        .ctl             (ctl),
        .val             (val),
        .contrast_gain   (gain_reg),
        .contrast_offset (offset_reg),
        .m_data          (m_data)
    );

endmodule

// File: design/cri_pipe_ctrl.sv
module cri_pipe_ctrl
    import cri_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output pipe_ctl_t ctl
);

    stage_vec_t valid_reg;
    stage_vec_t valid_next;
    stage_vec_t load;

    // A stage loads when it is empty or its contents move on this cycle
    always_comb begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    always_comb begin
        valid_next[0] = load[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready  = load[0];
    assign m_valid  = valid_reg[NUM_STAGES-1];
    assign ctl.load = load;

endmodule

// File: design/cri_front.sv
module cri_front
    import cri_pkg::*;
(
    input  logic       aclk,
    input  pipe_ctl_t  ctl,
    input  in_item_t   in_data,
    output wgt_vec_t   wy,
    output wgt_vec_t   wx,
    output quad_vec_t  quad,
    output smp_block_t smp
);

    localparam logic [LIN_W-1:0] ONE_LIN = LIN_W'(1) << FRAC_BITS;

    // Catmull-Rom weights over 2*S^3, all in modulo WGT_W arithmetic
    function automatic wgt_vec_t cr_weights(frac_t t, logic [T2_W-1:0] t2,
                                            logic [T3_W-1:0] t3);
        wgt_t     st;
        wgt_t     st2;
        wgt_t     st3;
        wgt_t     one3;
        wgt_vec_t w;
        st   = {{(WGT_W-FRAC_BITS){1'b0}}, t};
        st2  = {{(WGT_W-T2_W){1'b0}}, t2};
        st3  = {{(WGT_W-T3_W){1'b0}}, t3};
        one3 = wgt_t'(1) <<< (3 * FRAC_BITS + 1);
        w[0] = (st2 <<< (FRAC_BITS + 1)) - (st <<< (2 * FRAC_BITS)) - st3;
        w[1] = one3 - ((st2 <<< (FRAC_BITS + 2)) + (st2 <<< FRAC_BITS))
             + ((st3 <<< 1) + st3);
        w[2] = (st <<< (2 * FRAC_BITS)) + (st2 <<< (FRAC_BITS + 2))
             - ((st3 <<< 1) + st3);
        w[3] = st3 - (st2 <<< FRAC_BITS);
        return w;
    endfunction

    frac_t             tx1_reg, ty1_reg, tx2_reg, ty2_reg;
    logic [T2_W-1:0]   txx1_reg, tyy1_reg, txx2_reg, tyy2_reg;
    logic [T3_W-1:0]   txxx2_reg, tyyy2_reg;
    logic [LIN_W-1:0]  lx0_reg, lx1_reg, ly0_reg, ly1_reg;
    quad_vec_t         quad2_reg, quad3_reg;
    smp_block_t        smp1_reg, smp2_reg, smp3_reg;
    wgt_vec_t          wy3_reg, wx3_reg;
    frac_t             tx, ty;
    smp_block_t        smp_in;

    assign tx = in_data.frac_x[FRAC_BITS-1:0];
    assign ty = in_data.frac_y[FRAC_BITS-1:0];

    assign smp_in[0] = smp_row_t'(in_data.samples_row0);
    assign smp_in[1] = smp_row_t'(in_data.samples_row1);
    assign smp_in[2] = smp_row_t'(in_data.samples_row2);
    assign smp_in[3] = smp_row_t'(in_data.samples_row3);

    // Squares and linear weights
    always_ff @(posedge aclk) begin
        if (ctl.load[ST_SQR]) begin
            tx1_reg  <= tx;
            ty1_reg  <= ty;
            txx1_reg <= T2_W'(tx) * T2_W'(tx);
            tyy1_reg <= T2_W'(ty) * T2_W'(ty);
            lx0_reg  <= ONE_LIN - LIN_W'(tx);
            lx1_reg  <= LIN_W'(tx);
            ly0_reg  <= ONE_LIN - LIN_W'(ty);
            ly1_reg  <= LIN_W'(ty);
            smp1_reg <= smp_in;
        end
    end

    // Cubes and bilinear corner products
    always_ff @(posedge aclk) begin
        if (ctl.load[ST_CUBE]) begin
            tx2_reg      <= tx1_reg;
            ty2_reg      <= ty1_reg;
            txx2_reg     <= txx1_reg;
            tyy2_reg     <= tyy1_reg;
            txxx2_reg    <= T3_W'(txx1_reg) * T3_W'(tx1_reg);
            tyyy2_reg    <= T3_W'(tyy1_reg) * T3_W'(ty1_reg);
            quad2_reg[0] <= QUAD_W'(ly0_reg) * QUAD_W'(lx0_reg);
            quad2_reg[1] <= QUAD_W'(ly0_reg) * QUAD_W'(lx1_reg);
            quad2_reg[2] <= QUAD_W'(ly1_reg) * QUAD_W'(lx0_reg);
            quad2_reg[3] <= QUAD_W'(ly1_reg) * QUAD_W'(lx1_reg);
            smp2_reg     <= smp1_reg;
        end
    end

    // Cubic weights
    always_ff @(posedge aclk) begin
        if (ctl.load[ST_WGT]) begin
            wy3_reg   <= cr_weights(ty2_reg, tyy2_reg, tyyy2_reg);
            wx3_reg   <= cr_weights(tx2_reg, txx2_reg, txxx2_reg);
            quad3_reg <= quad2_reg;
            smp3_reg  <= smp2_reg;
        end
    end

    assign wy   = wy3_reg;
    assign wx   = wx3_reg;
    assign quad = quad3_reg;
    assign smp  = smp3_reg;

endmodule

// File: design/cri_filter.sv
module cri_filter
    import cri_pkg::*;
(
    input  logic       aclk,
    input  pipe_ctl_t  ctl,
    input  logic       interp_mode,
    input  wgt_vec_t   wy,
    input  wgt_vec_t   wx,
    input  quad_vec_t  quad,
    input  smp_block_t smp,
    output val_t       val
);

    localparam int YP_W = SAMPLE_BITS + WGT_W + 1;
    localparam int YS_W = YP_W + 2;
    localparam int BP_W = SAMPLE_BITS + QUAD_W;
    localparam int BS_W = BP_W + 2;
    localparam int XP_W = COL_W + WGT_W;
    localparam int XS_W = XP_W + 2;

    typedef logic signed [YP_W-1:0] yp_t;
    typedef logic signed [COL_W-1:0] col_t;
    typedef logic signed [XP_W-1:0] xp_t;

    yp_t [TAPS-1:0][TAPS-1:0] yp4_reg;      // [column][row]
    logic [TAPS-1:0][BP_W-1:0] bp4_reg;
    wgt_vec_t                 wx4_reg, wx5_reg;
    col_t [TAPS-1:0]          col5_reg;
    val_t                     bval5_reg, bval6_reg, val7_reg;
    xp_t [TAPS-1:0]           xp6_reg;

    logic signed [YS_W-1:0]   ysum [TAPS];
    logic [BS_W-1:0]          bsum;
    logic signed [XS_W-1:0]   xsum;
    val_t                     cval;
    sample_t [TAPS-1:0]       bsmp;

    // Bilinear uses the center 2x2, matched to the corner products
    assign bsmp[0] = smp[1][1];
    assign bsmp[1] = smp[1][2];
    assign bsmp[2] = smp[2][1];
    assign bsmp[3] = smp[2][2];

    always_ff @(posedge aclk) begin
        if (ctl.load[ST_YMUL]) begin
            for (int i = 0; i < TAPS; i++) begin
                for (int j = 0; j < TAPS; j++) begin
                    yp4_reg[i][j] <= YP_W'($signed({1'b0, smp[j][i]})) * YP_W'(wy[j]);
                end
                bp4_reg[i] <= BP_W'(bsmp[i]) * BP_W'(quad[i]);
            end
            wx4_reg <= wx;
        end
    end

    // Column sums, rounded half up to FRAC_BITS fraction bits
    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            ysum[i] = YS_W'(yp4_reg[i][0]) + YS_W'(yp4_reg[i][1])
                    + YS_W'(yp4_reg[i][2]) + YS_W'(yp4_reg[i][3])
                    + (YS_W'(1) <<< (2 * FRAC_BITS));
        end
        bsum = BS_W'(bp4_reg[0]) + BS_W'(bp4_reg[1]) + BS_W'(bp4_reg[2])
             + BS_W'(bp4_reg[3]) + (BS_W'(1) << (FRAC_BITS - 1));
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[ST_YSUM]) begin
            for (int i = 0; i < TAPS; i++) begin
                col5_reg[i] <= COL_W'(ysum[i] >>> (2 * FRAC_BITS + 1));
            end
            bval5_reg <= VAL_W'(bsum >> FRAC_BITS);
            wx5_reg   <= wx4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[ST_XMUL]) begin
            for (int i = 0; i < TAPS; i++) begin
                xp6_reg[i] <= XP_W'(col5_reg[i]) * XP_W'(wx5_reg[i]);
            end
            bval6_reg <= bval5_reg;
        end
    end

    always_comb begin
        xsum = XS_W'(xp6_reg[0]) + XS_W'(xp6_reg[1]) + XS_W'(xp6_reg[2])
             + XS_W'(xp6_reg[3]) + (XS_W'(1) <<< (3 * FRAC_BITS));
        cval = VAL_W'(xsum >>> (3 * FRAC_BITS + 1));
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[ST_XSUM]) begin
            val7_reg <= interp_mode ? cval : bval6_reg;
        end
    end

    assign val = val7_reg;

endmodule

// File: design/cri_contrast.sv
module cri_contrast
    import cri_pkg::*;
(
    input  logic                          aclk,
    input  pipe_ctl_t                     ctl,
    input  val_t                          val,
    input  logic [GAIN_BITS-1:0]          contrast_gain,
    input  logic signed [OFFSET_BITS-1:0] contrast_offset,
    output out_item_t                     m_data
);

    localparam int GP_W  = GAIN_BITS + VAL_W + 1;
    localparam int SHIFT = GAIN_FRAC + FRAC_BITS;
    localparam int G_W   = GP_W - SHIFT + 1;

    logic signed [GP_W-1:0] gp8_reg;
    logic signed [G_W-1:0]  g;
    out_item_t              out_next;
    out_item_t              out_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load[ST_GAIN]) begin
            gp8_reg <= GP_W'($signed({1'b0, contrast_gain})) * GP_W'(val);
        end
    end

    // Floor the scaled product, add the offset, saturate
    always_comb begin
        g = G_W'(gp8_reg >>> SHIFT) + G_W'(contrast_offset);
        out_next.clipped = 1'b0;
        if (g < 0) begin
            out_next.pixel_out = '0;
            out_next.clipped   = 1'b1;
        end else if (g > G_W'($signed({1'b0, SAMPLE_MAX}))) begin
            out_next.pixel_out = SAMPLE_MAX;
            out_next.clipped   = 1'b1;
        end else begin
            out_next.pixel_out = SAMPLE_BITS'(g);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[ST_OUT]) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

// File: design/cri_checker.sv
module cri_checker
    import cri_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped or changed while stalled");

    // Drop all results on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

    // An empty output stage means the whole pipe can advance
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output stage");

    // A clipped result sits at one of the rails
    a_clip_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.clipped) |->
            (m_data.pixel_out == '0 || m_data.pixel_out == SAMPLE_MAX))
        else $error("clip flag without saturated pixel");

endmodule

bind cell_interpolator_with_contrast cri_checker u_checker (.*);

// File: verif/cell_interpolator_with_contrast_test.sv
module cell_interpolator_with_contrast_test;
    import cri_pkg::*;

    // Settle time after the last expected pixel, before touching a register
    // or ending the run.
    localparam int SETTLE_CYCLES = NUM_STAGES + 3;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_REQUESTS = 150;
    // Register index that decodes to nothing; writes to it must be dropped.
    localparam logic [CFG_INDEX_BITS-1:0] UNUSED_REG_INDEX = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    cell_interpolator_with_contrast dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Shadow copy of the three registers, starting at their reset values.
    logic                   cfg_mode = 1'b0;
    logic [GAIN_BITS-1:0]   cfg_gain = 16'd256;
    logic [OFFSET_BITS-1:0] cfg_offset = '0;

    // Pixels still owed by the block, oldest first.
    out_item_t expected_pixels[$];

    int failures = 0;
    int sent_count = 0;
    int checked_count = 0;
    int directed_count = 0;
    int settings_count = 0;
    int burst_left = 1;
    int unsigned clk_count = 0;

    // One row of the directed stimulus: register values to hold, the request,
    // and a hand-typed result where one is obvious.
    typedef struct {
        logic [CFG_DATA_BITS-1:0] mode_w;
        logic [CFG_DATA_BITS-1:0] gain_w;
        logic [CFG_DATA_BITS-1:0] offset_w;
        in_item_t                 req;
        bit                       known;
        out_item_t                result;
    } probe_t;

    probe_t probes[$];

    function automatic longint div_floor(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) < 0)
            q -= 1;
        return q;
    endfunction

    // Catmull-Rom over four fixed-point values; weights are exact over 2*S^3,
    // the sum is rounded half up back to FRAC_BITS fraction bits.
    function automatic longint catmull_rom(longint p0, longint p1, longint p2,
                                           longint p3, longint t);
        longint s, s2, s3, t2, t3, acc;
        s = longint'(1) << FRAC_BITS;
        s2 = s * s;
        s3 = s2 * s;
        t2 = t * t;
        t3 = t2 * t;
        acc = p0 * (-t * s2 + 2 * t2 * s - t3)
            + p1 * (2 * s3 - 5 * t2 * s + 3 * t3)
            + p2 * (t * s2 + 4 * t2 * s - 3 * t3)
            + p3 * (t3 - t2 * s);
        return div_floor(acc + s3, 2 * s3);
    endfunction

    // Interpolate one cell under the shadow registers, then apply contrast,
    // floor and saturate.
    function automatic out_item_t predict_pixel(in_item_t req);
        logic [ROW_BITS-1:0] rows [4];
        longint smp [4][4];
        longint col [4];
        longint s, tx, ty, val, off, unity, g;
        out_item_t res;
        s = longint'(1) << FRAC_BITS;
        unity = longint'(1) << GAIN_FRAC;
        rows[0] = req.samples_row0;
        rows[1] = req.samples_row1;
        rows[2] = req.samples_row2;
        rows[3] = req.samples_row3;
        for (int j = 0; j < TAPS; j++)
            for (int i = 0; i < TAPS; i++)
                smp[j][i] = longint'(rows[j][SAMPLE_BITS*i +: SAMPLE_BITS]);
        tx = longint'(req.frac_x);
        ty = longint'(req.frac_y);
        if (cfg_mode) begin
            for (int i = 0; i < TAPS; i++)
                col[i] = catmull_rom(smp[0][i] * s, smp[1][i] * s, smp[2][i] * s,
                                     smp[3][i] * s, ty);
            val = catmull_rom(col[0], col[1], col[2], col[3], tx);
        end else begin
            val = div_floor(smp[1][1] * (s - tx) * (s - ty) + smp[1][2] * tx * (s - ty)
                          + smp[2][1] * (s - tx) * ty + smp[2][2] * tx * ty + s / 2, s);
        end
        off = longint'($signed(cfg_offset));
        g = div_floor(longint'(cfg_gain) * val + off * unity * s, unity * s);
        res.clipped = 1'b0;
        if (g < 0) begin
            g = 0;
            res.clipped = 1'b1;
        end else if (g > longint'(SAMPLE_MAX)) begin
            g = longint'(SAMPLE_MAX);
            res.clipped = 1'b1;
        end
        res.pixel_out = g[SAMPLE_BITS-1:0];
        return res;
    endfunction

    function automatic void add_row(int mode, int gain, int offset,
                                    logic [ROW_BITS-1:0] r0, logic [ROW_BITS-1:0] r1,
                                    logic [ROW_BITS-1:0] r2, logic [ROW_BITS-1:0] r3,
                                    logic [7:0] fx, logic [7:0] fy,
                                    bit known, logic [7:0] pix, logic clip);
        probe_t p;
        p.mode_w = 16'(mode);
        p.gain_w = 16'(gain);
        // Negative offsets carry ones in the upper bits; the block must drop them.
        p.offset_w = 16'(offset);
        p.req = '{samples_row0: r0, samples_row1: r1, samples_row2: r2,
                  samples_row3: r3, frac_x: fx, frac_y: fy};
        p.known = known;
        p.result = '{pixel_out: pix, clipped: clip};
        probes.push_back(p);
    endfunction

    function automatic void build_probes();
        // Reset settings: bilinear, unity gain, no offset.
        add_row(0, 256, 0, '1, '1, '1, '1, 8'h00, 8'h00, 1, 8'd255, 1'b0);
        add_row(0, 256, 0, '0, '0, '0, '0, 8'hFF, 8'hFF, 1, 8'd0, 1'b0);
        add_row(0, 256, 0, 32'h11223344, 32'h55667788, 32'h99AABBCC, 32'hDDEEFF00,
                8'h80, 8'h80, 0, 8'd0, 1'b0);
        add_row(0, 256, 0, 32'h11223344, 32'h55667788, 32'h99AABBCC, 32'hDDEEFF00,
                8'hFF, 8'h00, 0, 8'd0, 1'b0);
        add_row(0, 256, 0, 32'h11223344, 32'h55667788, 32'h99AABBCC, 32'hDDEEFF00,
                8'h00, 8'hFF, 0, 8'd0, 1'b0);
        add_row(0, 256, 0, 32'h00FF00FF, 32'hFF00FF00, 32'h00FF00FF, 32'hFF00FF00,
                8'h40, 8'hC0, 0, 8'd0, 1'b0);
        // Bicubic: a flat field comes back unchanged, a ridge overshoots high,
        // a trough undershoots below zero; both saturate and raise the clip flag.
        add_row(1, 256, 0, {4{8'h80}}, {4{8'h80}}, {4{8'h80}}, {4{8'h80}},
                8'h37, 8'hC9, 1, 8'd128, 1'b0);
        add_row(1, 256, 0, 32'h00FFFF00, 32'h00FFFF00, 32'h00FFFF00, 32'h00FFFF00,
                8'h80, 8'h00, 1, 8'd255, 1'b1);
        add_row(1, 256, 0, 32'hFF0000FF, 32'hFF0000FF, 32'hFF0000FF, 32'hFF0000FF,
                8'h80, 8'h00, 1, 8'd0, 1'b1);
        add_row(1, 256, 0, '0, '1, '1, '0, 8'h00, 8'h80, 1, 8'd255, 1'b1);
        add_row(1, 256, 0, 32'h11223344, 32'h55667788, 32'h99AABBCC, 32'hDDEEFF00,
                8'h80, 8'h80, 0, 8'd0, 1'b0);
        add_row(1, 256, 0, '1, '1, '1, '1, 8'hFF, 8'hFF, 1, 8'd255, 1'b0);
        // Gain extremes.
        add_row(1, 0, 0, '1, '1, '1, '1, 8'hA5, 8'h5A, 1, 8'd0, 1'b0);
        add_row(1, 65535, 0, '1, '1, '1, '1, 8'h00, 8'h00, 1, 8'd255, 1'b1);
        add_row(1, 65535, 0, '0, '0, '0, '0, 8'h00, 8'h00, 1, 8'd0, 1'b0);
        add_row(1, 65535, 0, {4{8'h01}}, {4{8'h01}}, {4{8'h01}}, {4{8'h01}},
                8'h80, 8'h80, 0, 8'd0, 1'b0);
        // Offset extremes.
        add_row(0, 256, -255, '0, '0, '0, '0, 8'h00, 8'h00, 1, 8'd0, 1'b1);
        add_row(0, 256, -255, '1, '1, '1, '1, 8'h00, 8'h00, 1, 8'd0, 1'b0);
        add_row(0, 256, 255, '0, '0, '0, '0, 8'h00, 8'h00, 1, 8'd255, 1'b0);
        add_row(0, 256, 255, {4{8'h01}}, {4{8'h01}}, {4{8'h01}}, {4{8'h01}},
                8'h00, 8'h00, 1, 8'd255, 1'b1);
        // Half gain floors small values away; then an odd mix.
        add_row(0, 128, 0, {4{8'h01}}, {4{8'h01}}, {4{8'h01}}, {4{8'h01}},
                8'h00, 8'h00, 0, 8'd0, 1'b0);
        add_row(0, 128, 0, 32'h11223344, 32'h55667788, 32'h99AABBCC, 32'hDDEEFF00,
                8'hC3, 8'h3C, 0, 8'd0, 1'b0);
        add_row(1, 300, -7, 32'h00FF00FF, 32'hFF00FF00, 32'h00FF00FF, 32'hFF00FF00,
                8'hFF, 8'h80, 0, 8'd0, 1'b0);
    endfunction

    // Fractions mostly random, with the cell edges hit now and then.
    function automatic logic [7:0] pick_frac();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Neighborhoods: pure noise, smooth patches near one level, or a
    // two-level edge along x or y, which is where the cubic overshoots.
    function automatic in_item_t make_request();
        in_item_t it;
        logic [ROW_BITS-1:0] rows [4];
        int kind, base, lo, hi, split, v;
        bit by_col;
        kind = $urandom_range(0, 9);
        base = $urandom_range(0, 255);
        lo = $urandom_range(0, 255);
        hi = $urandom_range(0, 255);
        split = $urandom_range(1, 3);
        by_col = 1'($urandom_range(0, 1));
        for (int j = 0; j < TAPS; j++)
            for (int i = 0; i < TAPS; i++) begin
                if (kind < 2) begin
                    v = $urandom_range(0, 255);
                end else if (kind < 7) begin
                    v = base + $urandom_range(0, 31);
                    if (v > 255)
                        v = 255;
                end else begin
                    v = ((by_col ? i : j) < split) ? lo : hi;
                end
                rows[j][SAMPLE_BITS*i +: SAMPLE_BITS] = v[SAMPLE_BITS-1:0];
            end
        it.samples_row0 = rows[0];
        it.samples_row1 = rows[1];
        it.samples_row2 = rows[2];
        it.samples_row3 = rows[3];
        it.frac_x = pick_frac();
        it.frac_y = pick_frac();
        return it;
    endfunction

    // Present one request and hold it until the block takes it; queue the
    // pixel it owes. Valid stays up so the next request can follow at once.
    task automatic send_request(in_item_t req, bit use_given, out_item_t given);
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (s_ready !== 1'b1)
            @(posedge aclk);
        expected_pixels.push_back(use_given ? given : predict_pixel(req));
        sent_count++;
    endtask

    // Count down the current burst; at its end, drop valid for a random gap
    // unless this stretch runs back to back.
    task automatic pace_sender(bit steady);
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_INTERP_MODE:     cfg_mode = data[0];
            REG_CONTRAST_GAIN:   cfg_gain = data[GAIN_BITS-1:0];
            REG_CONTRAST_OFFSET: cfg_offset = data[OFFSET_BITS-1:0];
            default: ;
        endcase
    endtask

    // Drain the pipeline, let it settle, then rewrite every register (plus a
    // stray write to the unused index, which must change nothing).
    task automatic apply_settings(logic [CFG_DATA_BITS-1:0] mode_w,
                                  logic [CFG_DATA_BITS-1:0] gain_w,
                                  logic [CFG_DATA_BITS-1:0] offset_w);
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(REG_CONTRAST_OFFSET, offset_w);
        write_reg(UNUSED_REG_INDEX, CFG_DATA_BITS'($urandom_range(0, 65535)));
        write_reg(REG_INTERP_MODE, mode_w);
        write_reg(REG_CONTRAST_GAIN, gain_w);
        cfg_wr_en <= 1'b0;
        settings_count++;
    endtask

    // Result side: check each accepted pixel against the oldest expectation,
    // then pick the next ready value. The stall style rotates through four patterns:
    // always ready, mostly ready, mostly stalled, or a fixed on/off rhythm.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result, pixel_out %0d clipped %0b",
                         $time, m_data.pixel_out, m_data.clipped);
                failures++;
            end else begin
                want = expected_pixels.pop_front();
                checked_count++;
                if (m_data.pixel_out !== want.pixel_out) begin
                    $display("%0t: pixel_out mismatch, expected %0d, got %0d",
                             $time, want.pixel_out, m_data.pixel_out);
                    failures++;
                end
                if (m_data.clipped !== want.clipped) begin
                    $display("%0t: clipped mismatch, expected %0b, got %0b",
                             $time, want.clipped, m_data.clipped);
                    failures++;
                end
            end
        end
        clk_count++;
        case ((clk_count / 256) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ((clk_count % 7) < 4);
        endcase
    end

    // Hard stop in case the block hangs.
    initial begin
        #2000000;
        $display("cell_interpolator_with_contrast test failed");
        $finish;
    end

    initial begin
        logic [CFG_DATA_BITS-1:0] gain_w;
        int offset;
        build_probes();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows: rewrite registers only when a row asks for new values.
        foreach (probes[n]) begin
            if (probes[n].mode_w[0] != cfg_mode || probes[n].gain_w != cfg_gain ||
                probes[n].offset_w[OFFSET_BITS-1:0] != cfg_offset)
                apply_settings(probes[n].mode_w, probes[n].gain_w, probes[n].offset_w);
            send_request(probes[n].req, probes[n].known, probes[n].result);
            directed_count++;
            pace_sender(1'b0);
        end

        // Random phases: alternate the mode, sweep gain from unity to the
        // extremes, and move the offset; upper data bits carry random junk.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 4)
                0: gain_w = 16'd256;
                1: gain_w = 16'($urandom_range(192, 320));
                2: gain_w = 16'($urandom_range(0, 511));
                default: gain_w = (ph == 3) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            endcase
            if (ph == 0)
                offset = 0;
            else if (ph == 5)
                offset = -255;
            else if (ph == 6)
                offset = 255;
            else
                offset = $urandom_range(0, 128) - 64;
            apply_settings({15'($urandom_range(0, 32767)), 1'(ph)}, gain_w,
                           {7'($urandom_range(0, 127)), 9'(offset)});
            for (int k = 0; k < PHASE_REQUESTS; k++) begin
                send_request(make_request(), 1'b0, '0);
                // Run the first and fifth phases back to back.
                pace_sender(ph == 0 || ph == 4);
            end
        end

        s_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d requests (%0d directed) under %0d register settings;",
                 sent_count, directed_count, settings_count);
        $display("compared %0d pixels in bilinear and bicubic mode, %0d errors",
                 checked_count, failures);
        if (failures == 0 && expected_pixels.size() == 0)
            $display("cell_interpolator_with_contrast test passed");
        else
            $display("cell_interpolator_with_contrast test failed");
        $finish;
    end

endmodule
